// ===== design/ipv4cs_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4cs_pkg
// Shared types, constants and helpers for the IPv4 header and L4 checksum
// engine.
// ----------------------------------------------------------------------------
package ipv4cs_pkg;

  // payload kind reported with each result
  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_TCP  = 2'd1,
    KIND_UDP  = 2'd2,
    KIND_ICMP = 2'd3
  } kind_e;

  // result status
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_BAD_IHL = 2'd1,
    STATUS_SHORT   = 2'd2
  } status_e;

  // ip protocol numbers
  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_IGMP = 8'd2;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  // header byte positions
  localparam logic [15:0] POS_IHL       = 16'd0;
  localparam logic [15:0] POS_LEN_HI    = 16'd2;
  localparam logic [15:0] POS_LEN_LO    = 16'd3;
  localparam logic [15:0] POS_PROTO     = 16'd9;
  localparam logic [15:0] POS_CSUM_LO   = 16'd11;
  localparam logic [15:0] POS_PSEUDO_LO = 16'd13;
  localparam logic [15:0] POS_PSEUDO_HI = 16'd19;
  localparam logic [15:0] POS_MAX       = 16'hFFFF;

  localparam logic [5:0]  MIN_HDR_BYTES = 6'd20;
  localparam logic [15:0] MIN_FRAME     = 16'd4;

  // offset of the low byte of the l4 checksum field within the payload
  localparam logic [15:0] TCP_CSUM_LO  = 16'd17;
  localparam logic [15:0] UDP_CSUM_LO  = 16'd7;
  localparam logic [15:0] ICMP_CSUM_LO = 16'd3;

  // frame summary handed from the parser to the finishing stages
  typedef struct packed {
    logic [31:0] hdr_acc;
    logic [31:0] pay_acc;
    logic [5:0]  hdr_bytes;
    logic [15:0] total_len;
    logic [7:0]  proto;
    logic [7:0]  held_hi;
    logic [15:0] count;
  } frame_sum_t;

  function automatic kind_e kind_of(input logic [7:0] p);
    kind_e k;
    k = KIND_NONE;
    if (p == PROTO_TCP) k = KIND_TCP;
    else if (p == PROTO_UDP) k = KIND_UDP;
    else if (p == PROTO_ICMP || p == PROTO_IGMP) k = KIND_ICMP;
    return k;
  endfunction

  function automatic logic [15:0] csum_lo_off(input kind_e k);
    logic [15:0] off;
    case (k)
      KIND_TCP: off = TCP_CSUM_LO;
      KIND_UDP: off = UDP_CSUM_LO;
      default:  off = ICMP_CSUM_LO;
    endcase
    return off;
  endfunction

endpackage

// ===== design/ipv4cs_parse.sv =====
// ----------------------------------------------------------------------------
// ipv4cs_parse
// Input register and per-byte header parse; keeps the running header and
// l4 word sums and hands a frame summary on at frame end.
// ----------------------------------------------------------------------------
module ipv4cs_parse (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [7:0]             s_axis_tdata_i,   // data_byte
  input  logic                   s_axis_tlast_i,   // frame_end
  output logic                   sum_valid_o,
  input  logic                   sum_ready_i,
  output ipv4cs_pkg::frame_sum_t sum_o
);

  // input register
  logic       in_v_q, in_v_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       in_adv;

  // frame state
  logic [15:0] pos_q, pos_d;
  logic [5:0]  hb_q, hb_d;
  logic [15:0] tl_q, tl_d;
  logic [7:0]  pr_q, pr_d;
  logic [31:0] hacc_q, hacc_d;
  logic [31:0] pacc_q, pacc_d;
  logic [7:0]  held_q, held_d;
  logic        reached_q, reached_d;

  // next values for the byte in the input register
  logic [15:0] pos_n;
  logic [5:0]  hb_n;
  logic [15:0] tl_n;
  logic [7:0]  pr_n;
  logic [31:0] hacc_n, pacc_n;
  logic [7:0]  held_n;
  logic        reached_n;
  logic [15:0] word;
  logic [15:0] pay_off;
  logic        add_hdr, add_pseudo, add_pay;
  logic [31:0] pay_addend;
  ipv4cs_pkg::kind_e kind;

  // summary register
  logic                   sum_v_q, sum_v_d;
  ipv4cs_pkg::frame_sum_t sum_q;

  // handshake
  assign in_adv          = in_v_q && (!last_q || !sum_v_q || sum_ready_i);
  assign s_axis_tready_o = !in_v_q || in_adv;
  assign in_v_d          = s_axis_tready_o ? s_axis_tvalid_i : in_v_q;

  // per-byte parse and accumulate
  always_comb begin
    hb_n       = hb_q;
    tl_n       = tl_q;
    pr_n       = pr_q;
    hacc_n     = hacc_q;
    pacc_n     = pacc_q;
    held_n     = held_q;
    reached_n  = reached_q;
    word       = {held_q, byte_q};
    add_hdr    = 1'b0;
    add_pseudo = 1'b0;
    add_pay    = 1'b0;
    pay_off    = pos_q - {10'd0, hb_q};
    pay_addend = 32'd0;
    kind       = ipv4cs_pkg::kind_of(pr_q);
    if (!reached_q) begin
      if (pos_q == ipv4cs_pkg::POS_IHL) hb_n = {byte_q[3:0], 2'b00};
      if (pos_q == ipv4cs_pkg::POS_LEN_HI) tl_n = {byte_q, 8'd0};
      if (pos_q == ipv4cs_pkg::POS_LEN_LO) tl_n = tl_q | {8'd0, byte_q};
      if (pos_q == ipv4cs_pkg::POS_PROTO) pr_n = byte_q;
      kind    = ipv4cs_pkg::kind_of(pr_n);
      pay_off = pos_q - {10'd0, hb_n};
      if (!pos_q[0]) begin
        held_n = byte_q;
      end else begin
        add_hdr    = (pos_q < {10'd0, hb_n}) && (pos_q != ipv4cs_pkg::POS_CSUM_LO);
        add_pseudo = (kind == ipv4cs_pkg::KIND_TCP || kind == ipv4cs_pkg::KIND_UDP) &&
                     (pos_q >= ipv4cs_pkg::POS_PSEUDO_LO) &&
                     (pos_q <= ipv4cs_pkg::POS_PSEUDO_HI);
        add_pay    = (kind != ipv4cs_pkg::KIND_NONE) && (pos_q >= {10'd0, hb_n}) &&
                     (pos_q < tl_n) && (pay_off != ipv4cs_pkg::csum_lo_off(kind));
      end
      if (add_hdr) hacc_n = hacc_q + {16'd0, word};
      if (add_pseudo && add_pay) pay_addend = {15'd0, word, 1'b0};
      else if (add_pseudo || add_pay) pay_addend = {16'd0, word};
      pacc_n = pacc_q + pay_addend;
      if ((pos_q >= ipv4cs_pkg::POS_LEN_LO) &&
          (({1'b0, pos_q} + 17'd1) >= {1'b0, tl_n})) begin
        reached_n = 1'b1;
      end
    end
    pos_n = (pos_q != ipv4cs_pkg::POS_MAX) ? pos_q + 16'd1 : pos_q;
  end

  // state update, cleared after every frame end
  always_comb begin
    pos_d     = pos_q;
    hb_d      = hb_q;
    tl_d      = tl_q;
    pr_d      = pr_q;
    hacc_d    = hacc_q;
    pacc_d    = pacc_q;
    held_d    = held_q;
    reached_d = reached_q;
    if (in_adv) begin
      if (last_q) begin
        pos_d     = 16'd0;
        hb_d      = 6'd0;
        tl_d      = 16'd0;
        pr_d      = 8'd0;
        hacc_d    = 32'd0;
        pacc_d    = 32'd0;
        held_d    = 8'd0;
        reached_d = 1'b0;
      end else begin
        pos_d     = pos_n;
        hb_d      = hb_n;
        tl_d      = tl_n;
        pr_d      = pr_n;
        hacc_d    = hacc_n;
        pacc_d    = pacc_n;
        held_d    = held_n;
        reached_d = reached_n;
      end
    end
  end

  // summary valid
  always_comb begin
    sum_v_d = sum_v_q;
    if (sum_ready_i) sum_v_d = 1'b0;
    if (in_adv && last_q) sum_v_d = 1'b1;
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q    <= 1'b0;
      sum_v_q   <= 1'b0;
      pos_q     <= 16'd0;
      hb_q      <= 6'd0;
      tl_q      <= 16'd0;
      pr_q      <= 8'd0;
      hacc_q    <= 32'd0;
      pacc_q    <= 32'd0;
      held_q    <= 8'd0;
      reached_q <= 1'b0;
    end else begin
      in_v_q    <= in_v_d;
      sum_v_q   <= sum_v_d;
      pos_q     <= pos_d;
      hb_q      <= hb_d;
      tl_q      <= tl_d;
      pr_q      <= pr_d;
      hacc_q    <= hacc_d;
      pacc_q    <= pacc_d;
      held_q    <= held_d;
      reached_q <= reached_d;
    end
  end

  // input word and frame summary payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      byte_q <= s_axis_tdata_i;
      last_q <= s_axis_tlast_i;
    end
    if (in_adv && last_q) begin
      sum_q.hdr_acc   <= hacc_n;
      sum_q.pay_acc   <= pacc_n;
      sum_q.hdr_bytes <= hb_n;
      sum_q.total_len <= tl_n;
      sum_q.proto     <= pr_n;
      sum_q.held_hi   <= held_n;
      sum_q.count     <= pos_n;
    end
  end

  assign sum_valid_o = sum_v_q;
  assign sum_o       = sum_q;

endmodule

// ===== design/ipv4cs_finish.sv =====
// ----------------------------------------------------------------------------
// ipv4cs_finish
// Frame-end checks, pseudo-header and pad terms, then carry fold and
// complement into the result register.
// ----------------------------------------------------------------------------
module ipv4cs_finish (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   sum_valid_i,
  output logic                   sum_ready_o,
  input  ipv4cs_pkg::frame_sum_t sum_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [31:0]            m_axis_tdata_o,   // header_checksum, payload_checksum
  output logic [3:0]             m_axis_tuser_o    // payload_kind, status
);

  // check stage
  logic               chk_v_q, chk_v_d;
  logic [31:0]        chk_hacc_q;
  logic [31:0]        chk_pacc_q;
  logic               chk_pay_en_q;
  ipv4cs_pkg::kind_e   chk_kind_q;
  ipv4cs_pkg::status_e chk_status_q;

  // output register
  logic        out_v_q, out_v_d;
  logic [15:0] out_hdr_q, out_pay_q;
  logic [1:0]  out_kind_q, out_status_q;

  logic                out_free, chk_free;
  ipv4cs_pkg::kind_e   kind;
  ipv4cs_pkg::status_e status;
  logic [15:0]         plen;
  logic [31:0]         pseudo_term, pad_term, pay_total;

  function automatic logic [15:0] fold_not(input logic [31:0] s);
    logic [16:0] t;
    logic [16:0] u;
    t = {1'b0, s[31:16]} + {1'b0, s[15:0]};
    u = t + {16'd0, t[16]};
    return ~u[15:0];
  endfunction

  assign out_free    = !out_v_q || m_axis_tready_i;
  assign chk_free    = !chk_v_q || out_free;
  assign sum_ready_o = chk_free;

  // length checks and pseudo-header terms
  always_comb begin
    kind   = ipv4cs_pkg::kind_of(sum_i.proto);
    status = ipv4cs_pkg::STATUS_OK;
    if (sum_i.hdr_bytes < ipv4cs_pkg::MIN_HDR_BYTES) status = ipv4cs_pkg::STATUS_BAD_IHL;
    else if (sum_i.count < ipv4cs_pkg::MIN_FRAME) status = ipv4cs_pkg::STATUS_SHORT;
    else if (sum_i.total_len < {10'd0, sum_i.hdr_bytes}) status = ipv4cs_pkg::STATUS_BAD_IHL;
    else if (sum_i.count < sum_i.total_len) status = ipv4cs_pkg::STATUS_SHORT;
    plen        = sum_i.total_len - {10'd0, sum_i.hdr_bytes};
    pseudo_term = 32'd0;
    if (kind == ipv4cs_pkg::KIND_TCP || kind == ipv4cs_pkg::KIND_UDP) begin
      pseudo_term = {24'd0, sum_i.proto} + {16'd0, plen};
    end
    pad_term  = plen[0] ? {16'd0, sum_i.held_hi, 8'd0} : 32'd0;
    pay_total = sum_i.pay_acc + pseudo_term + pad_term;
  end

  // stage valids
  always_comb begin
    chk_v_d = chk_v_q;
    if (chk_free) chk_v_d = sum_valid_i;
    out_v_d = out_v_q;
    if (out_free) out_v_d = chk_v_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chk_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      chk_v_q <= chk_v_d;
      out_v_q <= out_v_d;
    end
  end

  // check stage and fold stage payload
  always_ff @(posedge clk_i) begin
    if (chk_free && sum_valid_i) begin
      chk_hacc_q   <= sum_i.hdr_acc;
      chk_pacc_q   <= pay_total;
      chk_pay_en_q <= (kind != ipv4cs_pkg::KIND_NONE);
      chk_kind_q   <= kind;
      chk_status_q <= status;
    end
    if (out_free && chk_v_q) begin
      out_kind_q   <= chk_kind_q;
      out_status_q <= chk_status_q;
      if (chk_status_q == ipv4cs_pkg::STATUS_OK) begin
        out_hdr_q <= fold_not(chk_hacc_q);
        out_pay_q <= chk_pay_en_q ? fold_not(chk_pacc_q) : 16'd0;
      end else begin
        out_hdr_q <= 16'd0;
        out_pay_q <= 16'd0;
      end
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {out_pay_q, out_hdr_q};
  assign m_axis_tuser_o  = {out_status_q, out_kind_q};

endmodule

// ===== design/ipv4_l4_checksum_engine_core.sv =====
// ----------------------------------------------------------------------------
// ipv4_l4_checksum_engine_core
// IPv4 header and TCP/UDP/ICMP/IGMP checksum engine, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
// Bytes of an IPv4 packet enter one per cycle unless the input is stalled,
// header first, with tlast on the final byte of the frame. The input takes a
// byte every cycle with no gaps except at a frame's last byte, which waits in
// the input register while the summary register is full and not taken; each
// byte goes through the input register and a single add into the running sums.
// One result word leaves per frame, through the summary, length check and
// carry fold registers behind the input register. A result that waits on
// m_axis_tready_i stalls only once the three finishing stages are full.
// Result status 0 means good, 1 a bad header length, 2 a short frame; on
// error both checksums read zero. Bytes beyond the total length are ignored.
module ipv4_l4_checksum_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_byte
  input  logic        s_axis_tlast_i,   // frame_end
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // header_checksum, payload_checksum
  output logic [3:0]  m_axis_tuser_o    // payload_kind, status
);

  logic                   sum_valid;
  logic                   sum_ready;
  ipv4cs_pkg::frame_sum_t frame_sum;

  // byte parse and running sums
  ipv4cs_parse u_parse (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .sum_valid_o     (sum_valid),
    .sum_ready_i     (sum_ready),
    .sum_o           (frame_sum)
  );

  // frame-end checks and fold
  ipv4cs_finish u_finish (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sum_valid_i     (sum_valid),
    .sum_ready_o     (sum_ready),
    .sum_i           (frame_sum),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

// ===== design/ipv4cs_checker.sv =====
// ----------------------------------------------------------------------------
// ipv4cs_checker
// Port-level checks for the checksum engine, bound to the top level.
// ----------------------------------------------------------------------------
module ipv4cs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [3:0]  m_axis_tuser_o
);

  // a stalled result word holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result word changed");

  // with no result pending the input side never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output");

  // error status clears both checksums
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[3:2] != ipv4cs_pkg::STATUS_OK) |->
      m_axis_tdata_o == 32'd0)
    else $error("checksum nonzero on error status");

  // no l4 kind means no payload checksum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o[1:0] == ipv4cs_pkg::KIND_NONE) |->
      m_axis_tdata_o[31:16] == 16'd0)
    else $error("payload checksum without l4 kind");

endmodule

bind ipv4_l4_checksum_engine_core ipv4cs_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

// ===== tb/ipv4_l4_checksum_engine_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_l4_checksum_engine_core_test
// Self-checking bench for the IPv4 header and L4 checksum engine.
// ----------------------------------------------------------------------------
// Packet bytes are streamed into the engine from a queue of frames: a few
// hand-built frames first, then random IPv4 frames (TCP, UDP, ICMP, IGMP and
// other protocols, odd payloads, trailing bytes, truncated frames, bad header
// lengths). A byte-level model of the parser
// runs on every accepted byte and queues the checksum word that each frame
// end should produce; result words are checked field by field in order.
// Both sides idle at random in two of the three phases, and the result side
// is held off once long enough for the engine to fill up and stall its input.
// ----------------------------------------------------------------------------
module ipv4_l4_checksum_engine_core_test;
  import ipv4cs_pkg::*;

  localparam int unsigned WATCHDOG_CYCLES = 5000;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned PHASE_BYTES     = 350;
  localparam int unsigned MAX_REPORTS     = 10;

  // one packet byte waiting to be sent
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pkt_byte_t;

  // checksum word expected at a frame end
  typedef struct packed {
    logic [15:0] hdr_csum;
    logic [15:0] pay_csum;
    kind_e       kind;
    status_e     status;
  } csum_word_t;

  // running parse state of the current frame
  typedef struct packed {
    logic [15:0] pos;
    logic [5:0]  hdr_len;
    logic [15:0] tot_len;
    logic [7:0]  proto;
    logic [31:0] hdr_acc;
    logic [31:0] pay_acc;
    logic [7:0]  held_hi;
    logic        len_done;
  } parse_st_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = 8'h00;   // data_byte
  logic        s_axis_tlast_i = 1'b0;    // frame_end
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;           // header_checksum, payload_checksum
  logic [3:0]  m_axis_tuser_o;           // payload_kind, status

  pkt_byte_t   pending_bytes[$];
  csum_word_t  expected_words[$];
  parse_st_t   parse_st = '0;

  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  logic        hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_cycles = 0;
  int unsigned bytes_queued = 0;
  int unsigned bytes_sent = 0;
  int unsigned words_checked = 0;
  int unsigned mismatches = 0;
  int unsigned status_seen[3];
  int unsigned kind_seen[4];
  pkt_byte_t   next_byte;

  ipv4_l4_checksum_engine_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic kind_e proto_kind(input logic [7:0] p);
    case (p)
      PROTO_TCP:              return KIND_TCP;
      PROTO_UDP:              return KIND_UDP;
      PROTO_ICMP, PROTO_IGMP: return KIND_ICMP;
      default:                return KIND_NONE;
    endcase
  endfunction

  // payload offset of the low byte of the l4 checksum field
  function automatic int unsigned l4_csum_lo(input kind_e k);
    case (k)
      KIND_TCP: return TCP_CSUM_LO;
      KIND_UDP: return UDP_CSUM_LO;
      default:  return ICMP_CSUM_LO;
    endcase
  endfunction

  // end-around carry fold, then one's complement
  function automatic logic [15:0] fold_complement(input logic [31:0] s);
    logic [31:0] t;
    t = {16'h0000, s[31:16]} + {16'h0000, s[15:0]};
    t = t + (t >> 16);
    return ~t[15:0];
  endfunction

  // advance the parse state by one byte, queue a word on frame end
  task automatic absorb_byte(input logic [7:0] b, input logic last);
    int unsigned p;
    int unsigned plen;
    kind_e       k;
    logic [31:0] w;
    logic [31:0] s;
    csum_word_t  cw;
    p = parse_st.pos;
    if (!parse_st.len_done) begin
      if (p == POS_IHL) parse_st.hdr_len = {b[3:0], 2'b00};
      if (p == POS_LEN_HI) parse_st.tot_len = {b, 8'h00};
      if (p == POS_LEN_LO) parse_st.tot_len[7:0] = b;
      if (p == POS_PROTO) parse_st.proto = b;
      k = proto_kind(parse_st.proto);
      if (p[0] == 1'b0) begin
        parse_st.held_hi = b;
      end else begin
        w = {16'h0000, parse_st.held_hi, b};
        if (p < parse_st.hdr_len && p != POS_CSUM_LO)
          parse_st.hdr_acc = parse_st.hdr_acc + w;
        if ((k == KIND_TCP || k == KIND_UDP) && p >= POS_PSEUDO_LO && p <= POS_PSEUDO_HI)
          parse_st.pay_acc = parse_st.pay_acc + w;
        if (k != KIND_NONE && p >= parse_st.hdr_len && p < parse_st.tot_len &&
            p - parse_st.hdr_len != l4_csum_lo(k))
          parse_st.pay_acc = parse_st.pay_acc + w;
      end
      if (p >= 3 && p + 1 >= parse_st.tot_len) parse_st.len_done = 1'b1;
    end
    if (parse_st.pos != POS_MAX) parse_st.pos = parse_st.pos + 16'd1;
    if (last) begin
      k = proto_kind(parse_st.proto);
      cw = '0;
      cw.kind = k;
      if (parse_st.hdr_len < MIN_HDR_BYTES) cw.status = STATUS_BAD_IHL;
      else if (parse_st.pos < MIN_FRAME) cw.status = STATUS_SHORT;
      else if (parse_st.tot_len < parse_st.hdr_len) cw.status = STATUS_BAD_IHL;
      else if (parse_st.pos < parse_st.tot_len) cw.status = STATUS_SHORT;
      else cw.status = STATUS_OK;
      if (cw.status == STATUS_OK) begin
        cw.hdr_csum = fold_complement(parse_st.hdr_acc);
        if (k != KIND_NONE) begin
          plen = parse_st.tot_len - parse_st.hdr_len;
          s = parse_st.pay_acc;
          if (k == KIND_TCP || k == KIND_UDP) s = s + parse_st.proto + plen;
          if (plen[0]) s = s + {16'h0000, parse_st.held_hi, 8'h00};
          cw.pay_csum = fold_complement(s);
        end
      end
      expected_words.push_back(cw);
      parse_st = '0;
    end
  endtask

  // queue one frame with the given header fields and random other bytes
  task automatic queue_frame(input logic [3:0] ihl, input logic [15:0] tot,
                             input logic [7:0] proto, input int unsigned nbytes);
    pkt_byte_t pb;
    for (int unsigned i = 0; i < nbytes; i++) begin
      pb.data = 8'($urandom_range(0, 255));
      if (i == POS_IHL) pb.data[3:0] = ihl;
      if (i == POS_LEN_HI) pb.data = tot[15:8];
      if (i == POS_LEN_LO) pb.data = tot[7:0];
      if (i == POS_PROTO) pb.data = proto;
      pb.last = (i == nbytes - 1);
      pending_bytes.push_back(pb);
    end
    bytes_queued += nbytes;
  endtask

  // mostly well-formed frames, with trailing bytes and broken frames mixed in
  task automatic queue_random_frame();
    int unsigned sel;
    int unsigned pick;
    int unsigned ihl;
    int unsigned hlen;
    int unsigned tot;
    int unsigned n;
    logic [7:0]  proto;
    sel = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    ihl = ($urandom_range(0, 1) != 0) ? 5 : $urandom_range(5, 15);
    hlen = ihl * 4;
    tot = hlen + $urandom_range(0, 40);
    n = tot;
    if (pick < 30) proto = PROTO_TCP;
    else if (pick < 55) proto = PROTO_UDP;
    else if (pick < 67) proto = PROTO_ICMP;
    else if (pick < 75) proto = PROTO_IGMP;
    else proto = 8'($urandom_range(0, 255));
    if (sel < 15) begin
      // bytes past the total length
      n = tot + $urandom_range(1, 8);
    end else if (sel < 23) begin
      // frame ends early
      n = $urandom_range(1, tot - 1);
    end else if (sel < 28) begin
      // header length below the minimum
      ihl = $urandom_range(0, 4);
      n = $urandom_range(1, 40);
    end else if (sel < 32) begin
      // total length smaller than the header
      tot = $urandom_range(0, hlen - 1);
      n = hlen + $urandom_range(0, 8);
    end else if (sel < 35) begin
      // arbitrary total length, short frame
      tot = $urandom_range(0, 65535);
      n = $urandom_range(1, 30);
    end
    queue_frame(4'(ihl), 16'(tot), proto, n);
  endtask

  // byte driver, model updated on every accepted byte
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= 8'h00;
      s_axis_tlast_i  <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        absorb_byte(s_axis_tdata_i, s_axis_tlast_i);
        bytes_sent++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          next_byte = pending_bytes.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= next_byte.data;
          s_axis_tlast_i  <= next_byte.last;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // long hold-off of the result side
  always @(posedge clk_i) begin
    if (hold_req) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // result monitor and ready generation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin : check_word
      csum_word_t exp_w;
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("[%0t] unexpected result word tdata=%h tuser=%h", $realtime,
                     m_axis_tdata_o, m_axis_tuser_o);
        end else begin
          exp_w = expected_words.pop_front();
          words_checked++;
          if (m_axis_tdata_o[15:0] !== exp_w.hdr_csum ||
              m_axis_tdata_o[31:16] !== exp_w.pay_csum ||
              m_axis_tuser_o[1:0] !== exp_w.kind ||
              m_axis_tuser_o[3:2] !== exp_w.status) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("[%0t] word %0d exp/act: hdr %h/%h pay %h/%h kind %0d/%0d st %0d/%0d",
                       $realtime, words_checked, exp_w.hdr_csum, m_axis_tdata_o[15:0],
                       exp_w.pay_csum, m_axis_tdata_o[31:16], exp_w.kind,
                       m_axis_tuser_o[1:0], exp_w.status, m_axis_tuser_o[3:2]);
          end else begin
            status_seen[exp_w.status]++;
            kind_seen[exp_w.kind]++;
          end
        end
      end
      m_axis_tready_i <= (hold_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        stall_cycles <= 0;
      end else begin
        stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_CYCLES) begin
          $display("watchdog: no word moved for %0d cycles", WATCHDOG_CYCLES);
          $display("FAIL ipv4_l4_checksum_engine_core");
          $finish;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // sender idles a little, receiver a lot
    tx_idle_pct = 20;
    rx_idle_pct = 76;
    // one byte with header length zero
    queue_frame(4'h0, 16'h0000, 8'h00, 1);
    // frame cut before the length is known
    queue_frame(4'h5, 16'd20, PROTO_TCP, 3);
    // bare header with every other byte at all ones, tcp with empty payload
    pending_bytes.push_back('{data: 8'hF5, last: 1'b0});
    pending_bytes.push_back('{data: 8'hFF, last: 1'b0});
    pending_bytes.push_back('{data: 8'h00, last: 1'b0});
    pending_bytes.push_back('{data: 8'd20, last: 1'b0});
    for (int i = 4; i < 20; i++)
      pending_bytes.push_back('{data: (i == POS_PROTO) ? PROTO_TCP : 8'hFF, last: i == 19});
    bytes_queued += 20;
    while (bytes_queued < PHASE_BYTES) queue_random_frame();
    while (pending_bytes.size() != 0) @(negedge clk_i);

    // sender idles a lot, receiver a little
    tx_idle_pct = 76;
    rx_idle_pct = 20;
    while (bytes_queued < 2 * PHASE_BYTES) queue_random_frame();
    while (pending_bytes.size() != 0) @(negedge clk_i);

    // no idling, with one long hold on the result side
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    while (bytes_queued < 3 * PHASE_BYTES) queue_random_frame();
    hold_req = 1'b1;
    @(negedge clk_i);
    hold_req = 1'b0;

    while (pending_bytes.size() != 0 || s_axis_tvalid_i) @(negedge clk_i);
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    $display("sent %0d bytes, checked %0d frames: %0d ok, %0d bad header length, %0d short",
             bytes_sent, words_checked, status_seen[STATUS_OK], status_seen[STATUS_BAD_IHL],
             status_seen[STATUS_SHORT]);
    $display("payload kinds seen: none %0d, tcp %0d, udp %0d, icmp/igmp %0d; mismatches %0d",
             kind_seen[KIND_NONE], kind_seen[KIND_TCP], kind_seen[KIND_UDP],
             kind_seen[KIND_ICMP], mismatches);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("PASS ipv4_l4_checksum_engine_core");
    end else begin
      $display("FAIL ipv4_l4_checksum_engine_core");
    end
    $finish;
  end

endmodule
